FILE: sv/miq_pkg.sv
// ----------------------------------------------------------------------------
// MPEG-4 inverse quantizer package
// Shared types, codes and constants of the inverse quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package miq_pkg;

  // Block geometry.
  localparam int unsigned BLOCK_COEFFS = 64;
  localparam int unsigned POS_W        = $clog2(BLOCK_COEFFS);
  localparam int unsigned MEM_DEPTH    = 2 * BLOCK_COEFFS;
  localparam int unsigned MEM_AW       = $clog2(MEM_DEPTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_COEFFS - 1);

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_PIXEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_INTRA_MAT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_INTER_MAT  = 2'd2;

  // Sample depth limits and reset value.
  localparam logic [3:0] BPP_MIN   = 4'd4;
  localparam logic [3:0] BPP_MAX   = 4'd12;
  localparam logic [3:0] BPP_RESET = 4'd8;

  // Input word kinds carried on tuser.
  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Output status codes carried on tuser.
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_BAD_QP = 1'b1;

  // Input word layout, last field in the lowest bits.
  typedef struct packed {
    logic [4:0]        pad;
    logic [5:0]        last_index;
    logic [8:0]        qp;
    logic              luma_block;
    logic              intra_block;
    logic [7:0]        weight;
    logic signed [11:0] level;
    logic [5:0]        position;
  } in_word_t;

  // How a coefficient is reconstructed.
  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,
    KIND_DC    = 2'd1,
    KIND_MAT   = 2'd2,
    KIND_PLAIN = 2'd3
  } kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL1 = 2'd1,
    ST_MUL2 = 2'd2,
    ST_FIN  = 2'd3
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: sv/miq_ctrl.sv
// ----------------------------------------------------------------------------
// Inverse quantizer controller
// Sequences one coefficient through two multiplier steps and a final step.
// ----------------------------------------------------------------------------
`default_nettype none

module miq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_op_i,
  output logic                in_ready_o,
  input  wire miq_pkg::stat_t stat_i,
  output miq_pkg::cmd_t       cmd_o
);

  miq_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= miq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state. A new word may enter while the last step finishes.
  always_comb begin
    state_d = state_q;
    case (state_q)
      miq_pkg::ST_IDLE: begin
        if (in_valid_i && (in_op_i == miq_pkg::OP_COEF)) begin
          state_d = miq_pkg::ST_MUL1;
        end
      end
      miq_pkg::ST_MUL1: state_d = miq_pkg::ST_MUL2;
      miq_pkg::ST_MUL2: state_d = miq_pkg::ST_FIN;
      miq_pkg::ST_FIN: begin
        if (stat_i.out_free) begin
          if (in_valid_i && (in_op_i == miq_pkg::OP_COEF)) begin
            state_d = miq_pkg::ST_MUL1;
          end else begin
            state_d = miq_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = miq_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      miq_pkg::ST_IDLE: in_ready_o = 1'b1;
      miq_pkg::ST_MUL1: cmd_o.mul1 = 1'b1;
      miq_pkg::ST_MUL2: cmd_o.mul2 = 1'b1;
      miq_pkg::ST_FIN: begin
        in_ready_o = stat_i.out_free;
        cmd_o.fin  = stat_i.out_free;
      end
      default: in_ready_o = 1'b0;
    endcase
    cmd_o.load = in_valid_i && in_ready_o;
  end

`ifndef SYNTHESIS
  // An accepted coefficient always starts the multiplier sequence.
  a_coef_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && (in_op_i == miq_pkg::OP_COEF)) |=> (state_q == miq_pkg::ST_MUL1))
    else $error("accepted coefficient did not start the sequence");

  // The first multiplier step is always followed by the second.
  a_mul_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == miq_pkg::ST_MUL1) |=> (state_q == miq_pkg::ST_MUL2))
    else $error("multiplier steps out of order");
`endif

endmodule

`default_nettype wire

FILE: sv/miq_dpath.sv
// ----------------------------------------------------------------------------
// Inverse quantizer datapath
// Configuration, weight memory, two multiplier steps, clipping, mismatch
// control and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module miq_dpath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [miq_pkg::IN_DATA_W-1:0]      in_data_i,
  input  wire logic                               in_op_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [miq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [miq_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire miq_pkg::cmd_t                      cmd_i,
  output miq_pkg::stat_t                          stat_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [miq_pkg::OUT_DATA_W-1:0]          out_data_o,
  output logic                                    out_status_o,
  output logic                                    out_last_o
);

  // DC scaler as a function of qp and component.
  function automatic logic [10:0] dc_mult(input logic [8:0] q, input logic luma);
    logic [10:0] qe;
    logic [10:0] res;
    qe = {2'b00, q};
    if (q < 9'd5) begin
      res = 11'd8;
    end else if (luma) begin
      if (q < 9'd9) begin
        res = qe << 1;
      end else if (q < 9'd25) begin
        res = qe + 11'd8;
      end else begin
        res = (qe << 1) - 11'd16;
      end
    end else begin
      if (q < 9'd25) begin
        res = (qe + 11'd13) >> 1;
      end else begin
        res = qe - 11'd6;
      end
    end
    return res;
  endfunction

  // Configuration registers.
  logic [3:0] bpp_q;
  logic       use_intra_q;
  logic       use_inter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q       <= miq_pkg::BPP_RESET;
      use_intra_q <= 1'b0;
      use_inter_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        miq_pkg::CFG_BITS_PER_PIXEL: bpp_q       <= cfg_data_i;
        miq_pkg::CFG_USE_INTRA_MAT:  use_intra_q <= cfg_data_i[0];
        miq_pkg::CFG_USE_INTER_MAT:  use_inter_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Limits that follow from the sample depth.
  logic [3:0]         bpp_c;
  logic [9:0]         qmax;
  logic signed [16:0] vmax;
  logic signed [16:0] vmin;

  always_comb begin
    if (bpp_q < miq_pkg::BPP_MIN) begin
      bpp_c = miq_pkg::BPP_MIN;
    end else if (bpp_q > miq_pkg::BPP_MAX) begin
      bpp_c = miq_pkg::BPP_MAX;
    end else begin
      bpp_c = bpp_q;
    end
    qmax = (10'd1 << (bpp_c - 4'd3)) - 10'd1;
    vmax = $signed((17'd1 << (bpp_c + 4'd3)) - 17'd1);
    vmin = ~vmax;
  end

  // Decode of the incoming word.
  miq_pkg::in_word_t w;
  logic                    w_bad;
  logic                    w_mat;
  logic [5:0]              w_last;
  miq_pkg::kind_e          w_kind;
  logic signed [13:0]      w_a;
  logic [10:0]             w_b;
  logic [miq_pkg::MEM_AW-1:0] w_addr;

  always_comb begin
    w      = miq_pkg::in_word_t'(in_data_i);
    w_bad  = (w.qp == 9'd0) || ({1'b0, w.qp} > qmax);
    w_mat  = w.intra_block ? use_intra_q : use_inter_q;
    w_last = (w.last_index == '0) ? miq_pkg::LAST_POS : w.last_index;
    w_addr = {w.intra_block, w.position};
    if (w_bad) begin
      w_kind = miq_pkg::KIND_PASS;
    end else if (w.intra_block && (w.position == '0)) begin
      w_kind = miq_pkg::KIND_DC;
    end else if ((w.position <= w_last) && (w.level != 12'sd0)) begin
      w_kind = w_mat ? miq_pkg::KIND_MAT : miq_pkg::KIND_PLAIN;
    end else begin
      w_kind = miq_pkg::KIND_PASS;
    end
    // Inter matrix coefficients use 2*level plus the sign.
    if ((w_kind == miq_pkg::KIND_MAT) && !w.intra_block) begin
      w_a = ({{2{w.level[11]}}, w.level} <<< 1) + (w.level[11] ? -14'sd1 : 14'sd1);
    end else begin
      w_a = {{2{w.level[11]}}, w.level};
    end
    w_b = (w_kind == miq_pkg::KIND_DC) ? dc_mult(w.qp, w.luma_block) : {2'b00, w.qp};
  end

  // Weight memory, written and read when a word is taken.
  logic [7:0] mem_q [miq_pkg::MEM_DEPTH];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (in_op_i == miq_pkg::OP_WRITE) begin
        mem_q[w_addr] <= w.weight;
      end else begin
        rd_q <= mem_q[w_addr];
      end
    end
  end

  // Per-coefficient registers.
  miq_pkg::kind_e     kind_q;
  logic signed [13:0] a_q;
  logic [10:0]        b_q;
  logic signed [11:0] lvl_q;
  logic [8:0]         qp_q;
  logic [5:0]         pos_q;
  logic               intra_q;
  logic               bad_q;
  logic               tog_q;
  logic               upd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (in_op_i == miq_pkg::OP_COEF)) begin
      kind_q  <= w_kind;
      a_q     <= w_a;
      b_q     <= w_b;
      lvl_q   <= w.level;
      qp_q    <= w.qp;
      pos_q   <= w.position;
      intra_q <= w.intra_block;
      bad_q   <= w_bad;
      tog_q   <= !w_bad && w_mat && (w.position == miq_pkg::LAST_POS);
      upd_q   <= (w_kind == miq_pkg::KIND_MAT) || ((w_kind == miq_pkg::KIND_DC) && w_mat);
    end
  end

  // First multiplier: level (or 2*level+sign) by scaler, weight or qp.
  logic signed [11:0] mul1_b;
  logic signed [25:0] prod1;
  logic signed [22:0] m1_q;

  assign mul1_b = (kind_q == miq_pkg::KIND_MAT) ? $signed({4'b0000, rd_q})
                                                : $signed({1'b0, b_q});
  assign prod1  = a_q * mul1_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      m1_q <= $signed(prod1[22:0]);
    end
  end

  // Second multiplier: weighted product by qp.
  logic signed [32:0] prod2;
  logic signed [30:0] m2_q;

  assign prod2 = m1_q * $signed({1'b0, qp_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) begin
      m2_q <= $signed(prod2[30:0]);
    end
  end

  // Final step: rounding toward zero, clipping, parity and mismatch toggle.
  logic               par_q;
  logic signed [30:0] mat_adj;
  logic signed [30:0] mat_sh;
  logic [8:0]         odd;
  logic signed [24:0] dbl;
  logic signed [24:0] plain;
  logic signed [15:0] v_pre;
  logic               par_base;
  logic               par_new;
  logic [15:0]        v_fin;

  always_comb begin
    // Matrix method, divide by 8 or 16 toward zero.
    mat_adj = m2_q + ((m2_q < 31'sd0) ? (intra_q ? 31'sd7 : 31'sd15) : 31'sd0);
    mat_sh  = intra_q ? (mat_adj >>> 3) : (mat_adj >>> 4);
    // Plain method, 2*qp*level plus or minus the odd qp.
    odd     = qp_q[0] ? qp_q : (qp_q - 9'd1);
    dbl     = $signed({m1_q[22], m1_q, 1'b0});
    if (lvl_q[11]) begin
      plain = dbl - $signed({16'd0, odd});
    end else begin
      plain = dbl + $signed({16'd0, odd});
    end
    case (kind_q)
      miq_pkg::KIND_DC: v_pre = $signed(m1_q[15:0]);
      miq_pkg::KIND_MAT: begin
        if (mat_sh > $signed({{14{vmax[16]}}, vmax})) begin
          v_pre = $signed(vmax[15:0]);
        end else if (mat_sh < $signed({{14{vmin[16]}}, vmin})) begin
          v_pre = $signed(vmin[15:0]);
        end else begin
          v_pre = $signed(mat_sh[15:0]);
        end
      end
      miq_pkg::KIND_PLAIN: begin
        if (lvl_q[11] && (plain < $signed({{8{vmin[16]}}, vmin}))) begin
          v_pre = $signed(vmin[15:0]);
        end else if (!lvl_q[11] && (plain > $signed({{8{vmax[16]}}, vmax}))) begin
          v_pre = $signed(vmax[15:0]);
        end else begin
          v_pre = $signed(plain[15:0]);
        end
      end
      default: v_pre = {{4{lvl_q[11]}}, lvl_q};
    endcase
    // Parity restarts at the first position of each block.
    par_base = (pos_q == '0) ? 1'b0 : par_q;
    par_new  = upd_q ? (par_base ^ v_pre[0]) : par_base;
    // The toggle flips the low bit: odd goes down by one, even goes up.
    v_fin    = v_pre;
    if (tog_q && !par_new) begin
      v_fin[0] = ~v_pre[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q <= 1'b0;
    end else if (cmd_i.fin) begin
      par_q <= par_new;
    end
  end

  // Output register.
  logic        m_valid_q;
  logic [15:0] m_data_q;
  logic        m_status_q;
  logic        m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      m_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      m_data_q   <= v_fin;
      m_status_q <= bad_q ? miq_pkg::STATUS_BAD_QP : miq_pkg::STATUS_OK;
      m_last_q   <= (pos_q == miq_pkg::LAST_POS);
    end
  end

  assign stat_o.out_free = !m_valid_q || out_ready_i;
  assign out_valid_o     = m_valid_q;
  assign out_data_o      = m_data_q;
  assign out_status_o    = m_status_q;
  assign out_last_o      = m_last_q;

`ifndef SYNTHESIS
  // A result is only finished into a free output register.
  a_fin_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |-> (!m_valid_q || out_ready_i))
    else $error("result written over a pending word");

  // The output word only appears after a final step.
  a_valid_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(cmd_i.fin))
    else $error("output valid without a final step");
`endif

endmodule

`default_nettype wire

FILE: sv/mpeg4_inverse_quantizer.sv
// Sequence: a taken coefficient passes two chained multiplier steps and a final
// clipping step that writes the output register once it is free; the next
// coefficient is taken as it finishes. Weight writes are taken one per cycle while idle.
// Reset: rst_ni clears control state, the parity and the configuration to its
// reset values; the weight memory keeps its contents and is undefined until written.
// ----------------------------------------------------------------------------
// MPEG-4 inverse quantizer
// Dequantizes 8x8 block coefficients with matrix or plain reconstruction and
// mismatch control; weight matrix entries are written through the same stream.
// ----------------------------------------------------------------------------
`default_nettype none

module mpeg4_inverse_quantizer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Fields from bit 0: position, level, weight, intra_block, luma_block,
  // qp, last_index, zero fill.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [miq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic                           s_axis_tuser,   // op
  // Fields from bit 0: value.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [miq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tuser,   // status
  output logic                                m_axis_tlast,
  input  wire logic                           cfg_we_i,
  input  wire logic [miq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [miq_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  miq_pkg::cmd_t  cmd;
  miq_pkg::stat_t stat;

  // Sequencer.
  miq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic, storage and output register.
  miq_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (s_axis_tdata),
    .in_op_i      (s_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire
